@@ rtl/r6m_pkg.sv @@
package r6m_pkg;

    localparam int MAX_DISKS = 16;
    localparam int DISK_W    = 4;
    localparam int CNT_W     = 5;
    localparam int PAGE_W    = 36;
    localparam int PB_W      = 25;
    localparam int SB_W      = 27;
    localparam int ADDR_W    = PAGE_W + PB_W;
    localparam int OFF_W     = 48;
    localparam int HALF_W    = 18;
    localparam int PROD_W    = HALF_W + PB_W;
    localparam int ROW_CUT   = 24;
    localparam int CFG_W     = 27;
    localparam int IDX_W     = 3;

    localparam logic [1:0] KIND_READ    = 2'd0;
    localparam logic [1:0] KIND_DESTAGE = 2'd1;
    localparam logic [1:0] KIND_WRITE   = 2'd2;

    localparam logic [IDX_W-1:0] REG_DISK_COUNT  = 3'd0;
    localparam logic [IDX_W-1:0] REG_PAGE_BYTES  = 3'd1;
    localparam logic [IDX_W-1:0] REG_STRIP_BYTES = 3'd2;
    localparam logic [IDX_W-1:0] REG_FAILED_DISK = 3'd3;
    localparam logic [IDX_W-1:0] REG_USER_IO     = 3'd4;

    typedef enum logic [2:0] {
        MODE_IMM,
        MODE_SINGLE,
        MODE_DEGRADED,
        MODE_DESTAGE,
        MODE_WRITE
    } mode_t;

    // Effective configuration, already clamped.
    typedef struct packed {
        logic [CNT_W-1:0]  n;
        logic [DISK_W-1:0] w;
        logic [PB_W-1:0]   pb;
        logic [SB_W-1:0]   sb;
        logic [DISK_W-1:0] failed;
        logic              uio;
    } cfg_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] addr;
    } addr_item_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] strip;
        logic [SB_W-1:0]   rem_a;
    } strip_item_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] row;
        logic [DISK_W-1:0] rem_b;
        logic [DISK_W-1:0] s;
        logic [SB_W-1:0]   rem_a;
    } row_item_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [DISK_W-1:0] data;
        logic [DISK_W-1:0] pd;
        logic [DISK_W-1:0] qd;
        logic [OFF_W-1:0]  off;
    } map_item_t;

endpackage

@@ rtl/r6m_addr_mul.sv @@
module r6m_addr_mul (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [1:0]               kind,
    input  logic [r6m_pkg::PAGE_W-1:0] page_number,
    input  r6m_pkg::cfg_t            cfg,
    output logic                     out_valid,
    output r6m_pkg::addr_item_t      out_item
);
    import r6m_pkg::*;

    logic              v1_reg;
    logic [1:0]        kind1_reg;
    logic [PROD_W-1:0] lo_reg;
    logic [PROD_W-1:0] hi_reg;
    logic [PROD_W-1:0] lo_next;
    logic [PROD_W-1:0] hi_next;
    logic              v2_reg;
    addr_item_t        item2_reg;
    addr_item_t        item2_next;

    // The 36 by 25 product is split into two 18 by 25 partial products.
    assign lo_next = {{PB_W{1'b0}}, page_number[HALF_W-1:0]} * {{HALF_W{1'b0}}, cfg.pb};
    assign hi_next = {{PB_W{1'b0}}, page_number[PAGE_W-1:HALF_W]} * {{HALF_W{1'b0}}, cfg.pb};

    always_comb
    begin
        item2_next.kind = kind1_reg;
        item2_next.addr = {{HALF_W{1'b0}}, lo_reg} + {hi_reg, {HALF_W{1'b0}}};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind1_reg <= kind;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            item2_reg <= item2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = item2_reg;
endmodule

@@ rtl/r6m_strip_div.sv @@
module r6m_strip_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  r6m_pkg::addr_item_t in_item,
    input  r6m_pkg::cfg_t       cfg,
    output logic                out_valid,
    output r6m_pkg::strip_item_t out_item
);
    import r6m_pkg::*;

    logic              v_reg    [1:ADDR_W];
    logic [1:0]        kind_reg [1:ADDR_W];
    logic [SB_W-1:0]   rem_reg  [1:ADDR_W];
    logic [ADDR_W-1:0] dq_reg   [1:ADDR_W];

    // One quotient bit per stage; the dividend shifts out the top while the
    // quotient shifts in at the bottom.
    for (genvar k = 0; k < ADDR_W; k++)
    begin : g_stage
        logic              v_in;
        logic [1:0]        kind_in;
        logic [SB_W-1:0]   rem_in;
        logic [ADDR_W-1:0] dq_in;
        logic [SB_W:0]     t;
        logic              ge;
        logic [SB_W:0]     diff;
        logic [SB_W-1:0]   rem_next;
        logic [ADDR_W-1:0] dq_next;

        if (k == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign kind_in = in_item.kind;
            assign rem_in  = '0;
            assign dq_in   = in_item.addr;
        end
        else
        begin : g_chain
            assign v_in    = v_reg[k];
            assign kind_in = kind_reg[k];
            assign rem_in  = rem_reg[k];
            assign dq_in   = dq_reg[k];
        end

        assign t        = {rem_in, dq_in[ADDR_W-1]};
        assign ge       = t >= {1'b0, cfg.sb};
        assign diff     = t - {1'b0, cfg.sb};
        assign rem_next = ge ? diff[SB_W-1:0] : t[SB_W-1:0];
        assign dq_next  = {dq_in[ADDR_W-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k+1] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                kind_reg[k+1] <= kind_in;
                rem_reg[k+1]  <= rem_next;
                dq_reg[k+1]   <= dq_next;
            end
        end
    end

    assign out_valid      = v_reg[ADDR_W];
    assign out_item.kind  = kind_reg[ADDR_W];
    assign out_item.strip = dq_reg[ADDR_W];
    assign out_item.rem_a = rem_reg[ADDR_W];
endmodule

@@ rtl/r6m_row_div.sv @@
module r6m_row_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  r6m_pkg::strip_item_t in_item,
    input  r6m_pkg::cfg_t        cfg,
    output logic                 out_valid,
    output r6m_pkg::row_item_t   out_item
);
    import r6m_pkg::*;

    logic              v_reg    [1:ADDR_W];
    logic [1:0]        kind_reg [1:ADDR_W];
    logic [DISK_W-1:0] rem_reg  [1:ADDR_W];
    logic [DISK_W-1:0] smod_reg [1:ADDR_W];
    logic [ADDR_W-1:0] dq_reg   [1:ADDR_W];
    logic [SB_W-1:0]   ra_reg   [1:ADDR_W];

    // Divides the strip by the data disk count. The row quotient appears
    // most significant bit first, so its residue modulo the disk count is
    // built up alongside it.
    for (genvar k = 0; k < ADDR_W; k++)
    begin : g_stage
        logic              v_in;
        logic [1:0]        kind_in;
        logic [DISK_W-1:0] rem_in;
        logic [DISK_W-1:0] smod_in;
        logic [ADDR_W-1:0] dq_in;
        logic [SB_W-1:0]   ra_in;
        logic [DISK_W:0]   t;
        logic              ge;
        logic [DISK_W:0]   diff;
        logic [DISK_W-1:0] rem_next;
        logic [DISK_W:0]   t2;
        logic [DISK_W:0]   diff2;
        logic [DISK_W-1:0] smod_next;

        if (k == 0)
        begin : g_first
            assign v_in    = in_valid;
            assign kind_in = in_item.kind;
            assign rem_in  = '0;
            assign smod_in = '0;
            assign dq_in   = in_item.strip;
            assign ra_in   = in_item.rem_a;
        end
        else
        begin : g_chain
            assign v_in    = v_reg[k];
            assign kind_in = kind_reg[k];
            assign rem_in  = rem_reg[k];
            assign smod_in = smod_reg[k];
            assign dq_in   = dq_reg[k];
            assign ra_in   = ra_reg[k];
        end

        assign t         = {rem_in, dq_in[ADDR_W-1]};
        assign ge        = t >= {1'b0, cfg.w};
        assign diff      = t - {1'b0, cfg.w};
        assign rem_next  = ge ? diff[DISK_W-1:0] : t[DISK_W-1:0];
        assign t2        = {smod_in, ge};
        assign diff2     = t2 - cfg.n;
        assign smod_next = (t2 >= cfg.n) ? diff2[DISK_W-1:0] : t2[DISK_W-1:0];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[k+1] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                kind_reg[k+1] <= kind_in;
                rem_reg[k+1]  <= rem_next;
                smod_reg[k+1] <= smod_next;
                dq_reg[k+1]   <= {dq_in[ADDR_W-2:0], ge};
                ra_reg[k+1]   <= ra_in;
            end
        end
    end

    assign out_valid      = v_reg[ADDR_W];
    assign out_item.kind  = kind_reg[ADDR_W];
    assign out_item.row   = dq_reg[ADDR_W];
    assign out_item.rem_b = rem_reg[ADDR_W];
    assign out_item.s     = smod_reg[ADDR_W];
    assign out_item.rem_a = ra_reg[ADDR_W];
endmodule

@@ rtl/r6m_map.sv @@
module r6m_map (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  r6m_pkg::row_item_t in_item,
    input  r6m_pkg::cfg_t      cfg,
    output logic               out_valid,
    output r6m_pkg::map_item_t out_item
);
    import r6m_pkg::*;

    localparam int P0_W = ROW_CUT + SB_W;

    logic              v1_reg;
    logic [1:0]        kind1_reg;
    logic [DISK_W-1:0] data1_reg;
    logic [DISK_W-1:0] pd1_reg;
    logic [DISK_W-1:0] qd1_reg;
    logic [P0_W-1:0]   p0_reg;
    logic [ROW_CUT-1:0] p1_reg;
    logic [SB_W-1:0]   ra1_reg;
    logic [CNT_W-1:0]  sd;
    logic [CNT_W-1:0]  sp;
    logic [CNT_W-1:0]  sq;
    logic [CNT_W-1:0]  dd;
    logic [CNT_W-1:0]  dp;
    logic [CNT_W-1:0]  dqq;
    logic [P0_W-1:0]   p0_next;
    logic [2*ROW_CUT-1:0] p1_full;
    logic              v2_reg;
    map_item_t         item2_reg;
    map_item_t         item2_next;

    // Each sum stays below twice the disk count, so one subtract reduces it.
    assign sd  = {1'b0, in_item.rem_b} + {1'b0, in_item.s};
    assign sp  = {1'b0, cfg.w} + {1'b0, in_item.s};
    assign sq  = sp + CNT_W'(1);
    assign dd  = sd - cfg.n;
    assign dp  = sp - cfg.n;
    assign dqq = sq - cfg.n;

    assign p0_next = {{SB_W{1'b0}}, in_item.row[ROW_CUT-1:0]} * {{ROW_CUT{1'b0}}, cfg.sb};
    assign p1_full = {{ROW_CUT{1'b0}}, in_item.row[2*ROW_CUT-1:ROW_CUT]}
                   * {{ROW_CUT{1'b0}}, cfg.sb[ROW_CUT-1:0]};

    always_comb
    begin
        item2_next.kind = kind1_reg;
        item2_next.data = data1_reg;
        item2_next.pd   = pd1_reg;
        item2_next.qd   = qd1_reg;
        item2_next.off  = p0_reg[OFF_W-1:0] + {p1_reg, {ROW_CUT{1'b0}}}
                        + {{(OFF_W-SB_W){1'b0}}, ra1_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind1_reg <= in_item.kind;
            data1_reg <= (sd >= cfg.n) ? dd[DISK_W-1:0] : sd[DISK_W-1:0];
            pd1_reg   <= (sp >= cfg.n) ? dp[DISK_W-1:0] : sp[DISK_W-1:0];
            qd1_reg   <= (sq >= cfg.n) ? dqq[DISK_W-1:0] : sq[DISK_W-1:0];
            p0_reg    <= p0_next;
            p1_reg    <= p1_full[ROW_CUT-1:0];
            ra1_reg   <= in_item.rem_a;
            item2_reg <= item2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_item  = item2_reg;
endmodule

@@ rtl/r6m_emit.sv @@
module r6m_emit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  r6m_pkg::map_item_t         in_item,
    input  r6m_pkg::cfg_t              cfg,
    output logic                       take,
    output logic                       strobe,
    output logic [r6m_pkg::DISK_W-1:0] target_disk,
    output logic [r6m_pkg::OFF_W-1:0]  disk_offset,
    output logic                       is_write,
    output logic                       notify_caller,
    output logic                       immediate_done,
    output logic                       last
);
    import r6m_pkg::*;

    logic              active_reg;
    logic              active_next;
    mode_t             mode_reg;
    mode_t             mode_next;
    logic [DISK_W-1:0] step_reg;
    logic [DISK_W-1:0] step_next;
    map_item_t         item_reg;
    logic [CNT_W-1:0]  rot;
    logic [CNT_W-1:0]  rot_sub;
    logic [DISK_W-1:0] rot_disk;
    logic [CNT_W-1:0]  n_m1;

    assign rot      = {1'b0, item_reg.data} + {1'b0, step_reg};
    assign rot_sub  = rot - cfg.n;
    assign rot_disk = (rot >= cfg.n) ? rot_sub[DISK_W-1:0] : rot[DISK_W-1:0];
    assign n_m1     = cfg.n - CNT_W'(1);

    always_comb
    begin
        target_disk    = item_reg.data;
        is_write       = 1'b0;
        notify_caller  = 1'b0;
        immediate_done = 1'b0;
        last           = 1'b0;
        case (mode_reg)
            MODE_IMM:
            begin
                notify_caller  = 1'b1;
                immediate_done = 1'b1;
                last           = 1'b1;
            end
            MODE_SINGLE:
            begin
                notify_caller = 1'b1;
                last          = 1'b1;
            end
            MODE_DEGRADED:
            begin
                target_disk   = rot_disk;
                notify_caller = (step_reg == DISK_W'(1));
                last          = (step_reg == DISK_W'(1));
            end
            MODE_DESTAGE:
            begin
                if (step_reg == DISK_W'(0))
                begin
                    target_disk = item_reg.pd;
                end
                else if (step_reg == DISK_W'(1))
                begin
                    target_disk = item_reg.qd;
                end
                else
                begin
                    notify_caller = 1'b1;
                    last          = 1'b1;
                end
            end
            MODE_WRITE:
            begin
                is_write = 1'b1;
                if (step_reg == DISK_W'(0))
                begin
                    notify_caller = 1'b1;
                end
                else if (step_reg == DISK_W'(1))
                begin
                    target_disk = item_reg.pd;
                end
                else
                begin
                    target_disk = item_reg.qd;
                    last        = 1'b1;
                end
            end
            default:
            begin
                last = 1'b1;
            end
        endcase
    end

    assign strobe      = active_reg;
    assign disk_offset = item_reg.off;
    assign take        = !active_reg || last;

    always_comb
    begin
        active_next = active_reg;
        mode_next   = mode_reg;
        step_next   = step_reg;
        if (take)
        begin
            active_next = in_valid;
            step_next   = '0;
            if (!cfg.uio)
            begin
                mode_next = MODE_IMM;
            end
            else if (in_item.kind == KIND_READ || in_item.kind == KIND_DESTAGE)
            begin
                if (in_item.data == cfg.failed)
                begin
                    mode_next = MODE_DEGRADED;
                    step_next = n_m1[DISK_W-1:0];
                end
                else if (in_item.kind == KIND_READ)
                begin
                    mode_next = MODE_SINGLE;
                end
                else
                begin
                    mode_next = MODE_DESTAGE;
                end
            end
            else
            begin
                mode_next = MODE_WRITE;
            end
        end
        else if (mode_reg == MODE_DEGRADED)
        begin
            step_next = step_reg - DISK_W'(1);
        end
        else
        begin
            step_next = step_reg + DISK_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            mode_reg   <= MODE_IMM;
            step_reg   <= '0;
        end
        else
        begin
            active_reg <= active_next;
            mode_reg   <= mode_next;
            step_reg   <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && in_valid)
        begin
            item_reg <= in_item;
        end
    end
endmodule

@@ rtl/raid6_request_mapper_unit.sv @@
// RAID-6 request mapper with rotating P and Q parity.
// A request word enters on kind and page_number at a rising edge where start
// is high and busy is low. The block maps the page to a data disk, a P disk,
// a Q disk and a byte offset, then issues one to fifteen disk command words.
// Each command word is shown for exactly one cycle with result_valid high;
// the receiver cannot hold it off.
// Configuration is written through cfg_we, cfg_addr and cfg_wdata, one
// register per cycle. The user must write it only while no request is in
// flight; the block itself does not enforce this.
// The first command word reaches the outputs through two multiply stages,
// a 61-stage strip divider, a 61-stage row divider, two mapping stages and
// the command issuer register. The pipeline takes a new request every
// cycle unless it stalls, and the command issuer sends one word per cycle.
// While the issuer still has words of a request left and the pipeline end
// holds the next request, the whole pipeline stalls and busy is high.
// Reset clears every valid bit and loads the configuration defaults:
// 8 disks, 64 KiB pages, 512 KiB strips, failed disk 0, user I/O off.
module raid6_request_mapper_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   kind,
    input  logic [r6m_pkg::PAGE_W-1:0]   page_number,
    input  logic                         cfg_we,
    input  logic [r6m_pkg::IDX_W-1:0]    cfg_addr,
    input  logic [r6m_pkg::CFG_W-1:0]    cfg_wdata,
    output logic                         result_valid,
    output logic [r6m_pkg::DISK_W-1:0]   target_disk,
    output logic [r6m_pkg::OFF_W-1:0]    disk_offset,
    output logic [r6m_pkg::PB_W-1:0]     length_bytes,
    output logic                         is_write,
    output logic                         notify_caller,
    output logic                         immediate_done,
    output logic                         last
);
    import r6m_pkg::*;

    logic [CNT_W-1:0]  disk_count_reg;
    logic [PB_W-1:0]   page_bytes_reg;
    logic [SB_W-1:0]   strip_bytes_reg;
    logic [DISK_W-1:0] failed_disk_reg;
    logic              user_io_reg;
    logic [CNT_W-1:0]  n_eff;
    cfg_t              cfg;

    logic        en;
    logic        take;
    logic        addr_valid;
    addr_item_t  addr_item;
    logic        strip_valid;
    strip_item_t strip_item;
    logic        row_valid;
    row_item_t   row_item;
    logic        map_valid;
    map_item_t   map_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disk_count_reg  <= CNT_W'(8);
            page_bytes_reg  <= PB_W'(65536);
            strip_bytes_reg <= SB_W'(524288);
            failed_disk_reg <= '0;
            user_io_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_DISK_COUNT:  disk_count_reg  <= cfg_wdata[CNT_W-1:0];
                REG_PAGE_BYTES:  page_bytes_reg  <= cfg_wdata[PB_W-1:0];
                REG_STRIP_BYTES: strip_bytes_reg <= cfg_wdata[SB_W-1:0];
                REG_FAILED_DISK: failed_disk_reg <= cfg_wdata[DISK_W-1:0];
                REG_USER_IO:     user_io_reg     <= cfg_wdata[0];
                default:         user_io_reg     <= user_io_reg;
            endcase
        end
    end

    // The disk count is clamped to the supported range, and a zero strip
    // size behaves as one byte.
    always_comb
    begin
        if (disk_count_reg < CNT_W'(4))
        begin
            n_eff = CNT_W'(4);
        end
        else if (disk_count_reg > CNT_W'(MAX_DISKS))
        begin
            n_eff = CNT_W'(MAX_DISKS);
        end
        else
        begin
            n_eff = disk_count_reg;
        end
        cfg.n      = n_eff;
        cfg.w      = DISK_W'(n_eff - CNT_W'(2));
        cfg.pb     = page_bytes_reg;
        cfg.sb     = (strip_bytes_reg == '0) ? SB_W'(1) : strip_bytes_reg;
        cfg.failed = failed_disk_reg;
        cfg.uio    = user_io_reg;
    end

    // The pipeline moves as one; it holds only when its last stage has a
    // request the command issuer cannot yet take.
    assign en   = !map_valid || take;
    assign busy = !en;

    r6m_addr_mul u_mul (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (start),
        .kind        (kind),
        .page_number (page_number),
        .cfg         (cfg),
        .out_valid   (addr_valid),
        .out_item    (addr_item)
    );

    r6m_strip_div u_strip (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (addr_valid),
        .in_item   (addr_item),
        .cfg       (cfg),
        .out_valid (strip_valid),
        .out_item  (strip_item)
    );

    r6m_row_div u_row (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (strip_valid),
        .in_item   (strip_item),
        .cfg       (cfg),
        .out_valid (row_valid),
        .out_item  (row_item)
    );

    r6m_map u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (row_valid),
        .in_item   (row_item),
        .cfg       (cfg),
        .out_valid (map_valid),
        .out_item  (map_item)
    );

    r6m_emit u_emit (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (map_valid),
        .in_item        (map_item),
        .cfg            (cfg),
        .take           (take),
        .strobe         (result_valid),
        .target_disk    (target_disk),
        .disk_offset    (disk_offset),
        .is_write       (is_write),
        .notify_caller  (notify_caller),
        .immediate_done (immediate_done),
        .last           (last)
    );

    assign length_bytes = page_bytes_reg;

`ifndef SYNTHESIS
    a_busy_only_while_issuing: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> result_valid)
        else $error("pipeline stalled with no command word going out");

    a_request_continues: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |=> result_valid)
        else $error("request ended without a final command word");

    a_immediate_is_final: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && immediate_done |-> last && notify_caller && !is_write)
        else $error("immediate completion word malformed");

    a_write_never_degraded: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && is_write && !last |=> result_valid && is_write)
        else $error("write request mixed with read commands");
`endif
endmodule

@@ sim/tb_raid6_request_mapper_unit.sv @@
`timescale 1ns / 100ps

module tb_raid6_request_mapper_unit;

    import r6m_pkg::*;

    // The fourth kind code, which the block handles as a write.
    localparam logic [1:0] KIND_OTHER = 2'd3;

    // One disk command word as the block issues it.
    typedef struct packed {
        logic [DISK_W-1:0] disk;
        logic [OFF_W-1:0]  off;
        logic [PB_W-1:0]   len;
        logic              wr;
        logic              notify;
        logic              imm;
        logic              last;
    } disk_cmd_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          kind;
    logic [PAGE_W-1:0]   page_number;
    logic                cfg_we;
    logic [IDX_W-1:0]    cfg_addr;
    logic [CFG_W-1:0]    cfg_wdata;
    logic                result_valid;
    logic [DISK_W-1:0]   target_disk;
    logic [OFF_W-1:0]    disk_offset;
    logic [PB_W-1:0]     length_bytes;
    logic                is_write;
    logic                notify_caller;
    logic                immediate_done;
    logic                last;

    raid6_request_mapper_unit DUT (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .kind(kind), .page_number(page_number),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .result_valid(result_valid), .target_disk(target_disk),
        .disk_offset(disk_offset), .length_bytes(length_bytes),
        .is_write(is_write), .notify_caller(notify_caller),
        .immediate_done(immediate_done), .last(last)
    );

    // Shadow copy of the configuration registers, as written.
    logic [4:0]  sh_disk_count;
    logic [24:0] sh_page_bytes;
    logic [26:0] sh_strip_bytes;
    logic [3:0]  sh_failed_disk;
    logic        sh_user_io;

    // Disk commands predicted but not yet seen at the outputs.
    disk_cmd_t pending_cmds[$];

    int errors;
    int requests_sent;
    int cmds_checked;
    int degraded_seen;
    bit no_idle;

    // Drain time, with generous slack over the block's pipeline depth.
    localparam int DRAIN_CYCLES = 400;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Predict the command words one request produces and queue them.
    task automatic predict_commands(input logic [1:0] k, input logic [PAGE_W-1:0] pg);
        logic [63:0]  n;
        logic [63:0]  w;
        logic [63:0]  sb;
        logic [127:0] addr;
        logic [127:0] strip;
        logic [127:0] row;
        logic [63:0]  s;
        logic [63:0]  data;
        logic [63:0]  pd;
        logic [63:0]  qd;
        logic [127:0] off_full;
        logic [OFF_W-1:0] off;
        disk_cmd_t c;
        n = sh_disk_count;
        if (n < 4) n = 4;
        if (n > MAX_DISKS) n = MAX_DISKS;
        w = n - 2;
        sb = (sh_strip_bytes == 0) ? 64'd1 : 64'(sh_strip_bytes);
        addr = 128'(pg) * 128'(sh_page_bytes);
        strip = addr / sb;
        row = strip / w;
        s = 64'(row % n);
        data = (64'(strip % w) + s) % n;
        pd = (w + s) % n;
        qd = (w + 1 + s) % n;
        off_full = row * sb + addr % sb;
        off = off_full[OFF_W-1:0];
        c.off = off;
        c.len = sh_page_bytes;
        c.imm = 1'b0;
        if (!sh_user_io) begin
            c.disk = data[3:0]; c.wr = 0; c.notify = 1; c.imm = 1; c.last = 1;
            pending_cmds.push_back(c);
        end
        else if (k != KIND_WRITE && k != KIND_OTHER) begin
            if (data == 64'(sh_failed_disk)) begin
                // Degraded read: every surviving disk, counting down, the
                // neighbor just after the data disk last.
                degraded_seen++;
                for (longint i = n - 1; i > 1; i--) begin
                    c.disk = 4'((data + i) % n); c.wr = 0; c.notify = 0; c.last = 0;
                    pending_cmds.push_back(c);
                end
                c.disk = 4'((data + 1) % n); c.wr = 0; c.notify = 1; c.last = 1;
                pending_cmds.push_back(c);
            end
            else if (k == KIND_READ) begin
                c.disk = data[3:0]; c.wr = 0; c.notify = 1; c.last = 1;
                pending_cmds.push_back(c);
            end
            else begin
                c.wr = 0;
                c.disk = pd[3:0]; c.notify = 0; c.last = 0; pending_cmds.push_back(c);
                c.disk = qd[3:0]; pending_cmds.push_back(c);
                c.disk = data[3:0]; c.notify = 1; c.last = 1; pending_cmds.push_back(c);
            end
        end
        else begin
            // Writes, including the unused fourth kind: data, then P, then Q.
            c.wr = 1;
            c.disk = data[3:0]; c.notify = 1; c.last = 0; pending_cmds.push_back(c);
            c.disk = pd[3:0]; c.notify = 0; pending_cmds.push_back(c);
            c.disk = qd[3:0]; c.last = 1; pending_cmds.push_back(c);
        end
    endtask

    // Send one request word, with a random idle gap before it unless the
    // no-idle stretch is active. start drops only during idle cycles, so
    // back-to-back requests keep it high.
    task automatic send_request(input logic [1:0] k, input logic [PAGE_W-1:0] pg);
        if (!no_idle) begin
            while ($urandom_range(99) < 13) begin
                start <= 1'b0;
                kind <= 2'($urandom);
                page_number <= {$urandom, $urandom};
                @(posedge clk);
            end
        end
        start <= 1'b1;
        kind <= k;
        page_number <= pg;
        @(posedge clk);
        while (busy) @(posedge clk);
        predict_commands(k, pg);
        requests_sent++;
    endtask

    // Wait until every predicted word arrived, then let the pipeline empty.
    task automatic wait_idle();
        int guard;
        guard = 0;
        start <= 1'b0;
        while (pending_cmds.size() != 0 && guard < 100000) begin
            @(posedge clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            REG_DISK_COUNT:  sh_disk_count  = val[4:0];
            REG_PAGE_BYTES:  sh_page_bytes  = val[24:0];
            REG_STRIP_BYTES: sh_strip_bytes = val[26:0];
            REG_FAILED_DISK: sh_failed_disk = val[3:0];
            REG_USER_IO:     sh_user_io     = val[0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [4:0] dc, input logic [24:0] pb,
                              input logic [26:0] sb, input logic [3:0] fd,
                              input logic uio);
        wait_idle();
        write_reg(REG_DISK_COUNT, CFG_W'(dc));
        write_reg(REG_PAGE_BYTES, CFG_W'(pb));
        write_reg(REG_STRIP_BYTES, CFG_W'(sb));
        write_reg(REG_FAILED_DISK, CFG_W'(fd));
        write_reg(REG_USER_IO, CFG_W'(uio));
        cfg_we <= 1'b0;
    endtask

    // Reset defaults with user I/O off: every request completes at once.
    task automatic test_immediate_completion();
        send_request(KIND_READ, '0);
        send_request(KIND_WRITE, '1);
        send_request(KIND_DESTAGE, 36'd12345);
    endtask

    // Every kind, including the fourth one, plus page extremes and a
    // page that lands on the failed disk.
    task automatic test_directed_kinds();
        set_config(5'd8, 25'd65536, 27'd524288, 4'd0, 1'b1);
        send_request(KIND_READ, '0);
        send_request(KIND_DESTAGE, '0);
        send_request(KIND_WRITE, '0);
        send_request(KIND_OTHER, 36'd7);
        send_request(KIND_READ, '1);
        send_request(KIND_WRITE, '1);
        send_request(KIND_READ, 36'd8);
        send_request(KIND_DESTAGE, 36'd16);
    endtask

    // Out-of-range disk counts, zero strip and page sizes, largest sizes,
    // and a failed disk index beyond the array.
    task automatic test_config_extremes();
        set_config(5'd0, 25'd1, 27'd0, 4'd2, 1'b1);
        send_request(KIND_READ, 36'd5);
        send_request(KIND_DESTAGE, 36'd9);
        set_config(5'd31, 25'h1FFFFFF, 27'h7FFFFFF, 4'd15, 1'b1);
        send_request(KIND_READ, '1);
        send_request(KIND_WRITE, 36'h123456789);
        send_request(KIND_READ, 36'd4);
        set_config(5'd16, 25'd0, 27'd1, 4'd3, 1'b1);
        send_request(KIND_DESTAGE, 36'd77);
        set_config(5'd4, 25'd4096, 27'd16384, 4'd15, 1'b1);
        send_request(KIND_READ, 36'd100);
        send_request(KIND_WRITE, 36'd3);
    endtask

    // Random requests over several random configurations. Small geometries
    // keep degraded reads frequent.
    task automatic test_random_traffic();
        logic [PAGE_W-1:0] pg;
        for (int phase = 0; phase < 6; phase++) begin
            set_config(5'($urandom_range(31)),
                       ($urandom_range(3) == 0) ? 25'($urandom) : 25'($urandom_range(1, 64)),
                       ($urandom_range(3) == 0) ? 27'($urandom) : 27'($urandom_range(0, 256)),
                       4'($urandom), ($urandom_range(4) != 0));
            no_idle = (phase == 3);
            for (int i = 0; i < 50; i++) begin
                case ($urandom_range(3))
                    0: pg = {$urandom, $urandom};
                    default: pg = 36'($urandom_range(0, 2000));
                endcase
                send_request(2'($urandom), pg);
            end
        end
        no_idle = 0;
    endtask

    // Compare every command word with the oldest prediction.
    always @(posedge clk) begin
        disk_cmd_t exp_cmd;
        if (rst_n && result_valid) begin
            if (pending_cmds.size() == 0) begin
                $error("command word with no prediction pending: disk %0d offset %0h",
                       target_disk, disk_offset);
                errors++;
            end
            else begin
                exp_cmd = pending_cmds.pop_front();
                cmds_checked++;
                if (target_disk !== exp_cmd.disk) begin
                    $error("target_disk expected %0d actual %0d", exp_cmd.disk, target_disk);
                    errors++;
                end
                if (disk_offset !== exp_cmd.off) begin
                    $error("disk_offset expected %0h actual %0h", exp_cmd.off, disk_offset);
                    errors++;
                end
                if (length_bytes !== exp_cmd.len) begin
                    $error("length_bytes expected %0d actual %0d", exp_cmd.len, length_bytes);
                    errors++;
                end
                if (is_write !== exp_cmd.wr) begin
                    $error("is_write expected %0b actual %0b", exp_cmd.wr, is_write);
                    errors++;
                end
                if (notify_caller !== exp_cmd.notify) begin
                    $error("notify_caller expected %0b actual %0b", exp_cmd.notify,
                           notify_caller);
                    errors++;
                end
                if (immediate_done !== exp_cmd.imm) begin
                    $error("immediate_done expected %0b actual %0b", exp_cmd.imm,
                           immediate_done);
                    errors++;
                end
                if (last !== exp_cmd.last) begin
                    $error("last expected %0b actual %0b", exp_cmd.last, last);
                    errors++;
                end
            end
        end
    end

    initial begin
        errors = 0;
        requests_sent = 0;
        cmds_checked = 0;
        degraded_seen = 0;
        no_idle = 0;
        rst_n = 1'b0;
        start = 1'b0;
        kind = '0;
        page_number = '0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        sh_disk_count = 5'd8;
        sh_page_bytes = 25'd65536;
        sh_strip_bytes = 27'd524288;
        sh_failed_disk = 4'd0;
        sh_user_io = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_immediate_completion();
        test_directed_kinds();
        test_config_extremes();
        test_random_traffic();
        wait_idle();

        if (pending_cmds.size() != 0) begin
            $error("%0d predicted command words never arrived", pending_cmds.size());
            errors++;
        end
        $display("Run covered %0d requests and %0d command words, %0d degraded reads.",
                 requests_sent, cmds_checked, degraded_seen);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #20ms;
        $display("FAIL");
        $finish;
    end

endmodule

@@ files.f @@
rtl/r6m_pkg.sv
rtl/r6m_addr_mul.sv
rtl/r6m_strip_div.sv
rtl/r6m_row_div.sv
rtl/r6m_map.sv
rtl/r6m_emit.sv
rtl/raid6_request_mapper_unit.sv
sim/tb_raid6_request_mapper_unit.sv
